// ===== sv/anf_mobius_transform_core_macros.svh =====
// Assertion macros used by the block's top-level RTL file.
`ifndef ANF_MOBIUS_TRANSFORM_CORE_MACROS_SVH
`define ANF_MOBIUS_TRANSFORM_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ANF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define ANF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ANF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define ANF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/anf_pkg.sv =====
// Package with the payload types and constants of the ANF transform block.
`timescale 1ns / 1ps
`default_nettype none

package anf_pkg;

    localparam int TERM_W  = 10;
    localparam int VALUE_W = 2;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0] CFG_ACTIVE_BITS_RESET = 4'd10;

    localparam int MAX_INPUT_BITS_DEFAULT = 10;
    localparam int OUTPUT_BITS_DEFAULT    = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [TERM_W-1:0] index;
        logic [VALUE_W-1:0] entry_value;
    } in_beat_t;

    typedef struct packed {
        logic [TERM_W-1:0]  term;
        logic [VALUE_W-1:0] coefficients;
        logic               any_present;
    } out_beat_t;

endpackage

`default_nettype wire

// ===== sv/anf_mobius_transform_core.sv =====
// Top level of the algebraic normal form (Moebius transform) lookup block.
//
//   Channel   Ports                          Direction   Beat
//   --------  -----------------------------  ----------  ---------------------------------
//   s_        s_valid s_ready s_data         in          write entry or read one term
//   m_        m_valid m_ready m_data         out         term, coefficients, any_present
//   cfg_      cfg_valid cfg_ready cfg_data   in          active_input_bits
//
// A write beat is stored in the table RAM at the edge that accepts it.
// A read beat of a term with k bits set walks all 2^k subsets of the term through the single
// read port of the table RAM, one address a cycle, and XORs the registered read data into
// an accumulator. A read out of range skips the walk and goes straight to the state that
// loads the result register.
// Reset clears the control state and sets active_input_bits to 10; the table RAM is not
// cleared, so every entry must be written before it is read.
// A result waits in the output register; if that register is still full when the next
// read finishes, the sequencer holds its sum until the beat ahead has been taken.
`timescale 1ns / 1ps
`default_nettype none
`include "anf_mobius_transform_core_macros.svh"

module anf_mobius_transform_core #(
    parameter int MAX_INPUT_BITS = anf_pkg::MAX_INPUT_BITS_DEFAULT,
    parameter int OUTPUT_BITS    = anf_pkg::OUTPUT_BITS_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire anf_pkg::in_beat_t        s_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output anf_pkg::out_beat_t            m_data,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [anf_pkg::CFG_W-1:0] cfg_data
);

    localparam int AW    = MAX_INPUT_BITS;
    localparam int OB    = OUTPUT_BITS;
    localparam int TW    = anf_pkg::TERM_W;
    localparam int VW    = anf_pkg::VALUE_W;
    localparam int EFF_W = 5;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [anf_pkg::CFG_W-1:0] active_bits_reg;
    logic [AW-1:0]       term_reg, term_next;
    logic [AW-1:0]       sub_reg, sub_next;
    logic [TW-1:0]       echo_reg, echo_next;
    logic [OB-1:0]       acc_reg, acc_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                m_valid_reg, m_valid_next;
    anf_pkg::out_beat_t  m_data_reg, m_data_next;

    logic [EFF_W-1:0]    eff_bits;
    logic                in_range;
    logic [TW+AW-1:0]    index_wide;
    logic [AW-1:0]       index_addr;
    logic [VW+OB-1:0]    value_wide;
    logic [OB-1:0]       ram_rdata;
    logic                ram_we;
    logic                ram_re;
    logic [OB-1:0]       acc_final;
    logic [OB+VW-1:0]    coef_wide;
    logic [VW-1:0]       coef;
    logic                out_free;
    logic                s_fire;

    // Active width saturates at the table's address width; the beat is in range
    // when no index bit sits at or above it.
    always_comb begin
        if (EFF_W'(active_bits_reg) > EFF_W'(MAX_INPUT_BITS)) begin
            eff_bits = EFF_W'(MAX_INPUT_BITS);
        end else begin
            eff_bits = EFF_W'(active_bits_reg);
        end
    end

    assign in_range   = (s_data.index >> eff_bits) == '0;
    assign index_wide = {{AW{1'b0}}, s_data.index};
    assign index_addr = index_wide[AW-1:0];
    assign value_wide = {{OB{1'b0}}, s_data.entry_value};

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign ram_we    = s_fire && (s_data.command == anf_pkg::CMD_WRITE) && in_range;
    assign ram_re    = (state_reg == ST_WALK);
    assign out_free  = !m_valid_reg || m_ready;

    // The last read data may still be in flight when the walk ends.
    assign acc_final = rd_pend_reg ? (acc_reg ^ ram_rdata) : acc_reg;
    assign coef_wide = {{VW{1'b0}}, acc_final};
    assign coef      = coef_wide[VW-1:0];

    anf_ram #(
        .WIDTH (OB),
        .DEPTH (2 ** AW)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (index_addr),
        .wdata (value_wide[OB-1:0]),
        .re    (ram_re),
        .raddr (sub_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        term_next    = term_reg;
        sub_next     = sub_reg;
        echo_next    = echo_reg;
        acc_next     = acc_final;
        rd_pend_next = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_data.command == anf_pkg::CMD_READ)) begin
                    echo_next = s_data.index;
                    term_next = index_addr;
                    sub_next  = index_addr;
                    acc_next  = '0;
                    // A term out of range skips the walk and returns zero.
                    state_next = in_range ? ST_WALK : ST_FIN;
                end
            end
            ST_WALK: begin
                // Subsets run from the term down to zero: s = (s - 1) & term.
                rd_pend_next = 1'b1;
                if (sub_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    sub_next = (sub_reg - AW'(1)) & term_reg;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.term         = echo_reg;
                    m_data_next.coefficients = coef;
                    m_data_next.any_present  = |coef;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            rd_pend_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            active_bits_reg <= anf_pkg::CFG_ACTIVE_BITS_RESET;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                active_bits_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        term_reg   <= term_next;
        sub_reg    <= sub_next;
        echo_reg   <= echo_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ANF_ASSERT_NOW(a_idle_no_read, aclk, aresetn, state_reg == ST_IDLE, !rd_pend_reg, "read data pending while idle")
    `ANF_ASSERT_NOW(a_sub_in_term, aclk, aresetn, state_reg == ST_WALK, (sub_reg & ~term_reg) == '0, "walk address is not a subset of the term")
    `ANF_ASSERT_NEXT(a_read_walks, aclk, aresetn, s_fire && (s_data.command == anf_pkg::CMD_READ) && in_range, state_reg == ST_WALK, "read in range did not start a walk")
    `ANF_ASSERT_NEXT(a_fin_loads, aclk, aresetn, (state_reg == ST_FIN) && out_free, m_valid_reg && (state_reg == ST_IDLE), "finished read did not load the result")

endmodule

`default_nettype wire

// ===== sv/anf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module anf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== dv/anf_mobius_transform_core_test.sv =====
// Self-checking testbench for the ANF transform block: table writes, term reads, width changes.
`timescale 1ns / 1ps

module anf_mobius_transform_core_test;
    import anf_pkg::*;

    localparam int MAX_BITS     = MAX_INPUT_BITS_DEFAULT;
    localparam int TABLE_DEPTH  = 1 << MAX_BITS;
    // The drain covers a full read, which walks 2^MAX_BITS addresses, plus margin.
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 76;
    localparam int HOLD_CYCLES  = 500;
    localparam int HOLD_AFTER   = 60;
    localparam int ITEM_GOAL    = 580;
    localparam int PHASES       = 11;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_e;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_beat_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_beat_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    anf_mobius_transform_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction state. Only the checking process below changes it, so it
    // always sees the beats in the order in which the block accepted them.
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0] table_img [TABLE_DEPTH];
    logic [CFG_W-1:0]   width_img;
    out_beat_t          coef_due [$];
    int                 err_count     = 0;
    int                 reads_checked = 0;
    int                 beats_in      = 0;

    // Number of table entries in range for a given register value; values
    // above the maximum width saturate.
    function automatic int span_of(logic [CFG_W-1:0] bits);
        return 1 << ((int'(bits) > MAX_BITS) ? MAX_BITS : int'(bits));
    endfunction

    // XOR of every stored entry whose index is a subset of the term.
    function automatic logic [VALUE_W-1:0] subset_xor(logic [TERM_W-1:0] term);
        logic [TERM_W-1:0]  sub;
        logic [VALUE_W-1:0] acc;
        bit                 done;
        sub  = term;
        acc  = '0;
        done = 1'b0;
        while (!done) begin
            acc ^= table_img[sub];
            if (sub == '0) begin
                done = 1'b1;
            end else begin
                sub = (sub - 1'b1) & term;
            end
        end
        return acc;
    endfunction

    // Apply one accepted input beat to the table image and queue the result
    // that a read will produce.
    function automatic void absorb_beat(in_beat_t beat);
        int        span;
        out_beat_t res;
        span = span_of(width_img);
        if (beat.command == CMD_WRITE) begin
            // Writes out of range are dropped by the block.
            if (int'(beat.index) < span) begin
                table_img[beat.index] = beat.entry_value;
            end
        end else begin
            res.term         = beat.index;
            res.coefficients = (int'(beat.index) < span) ? subset_xor(beat.index) : '0;
            res.any_present  = (res.coefficients != '0);
            coef_due.push_back(res);
        end
    endfunction

    // Checker. The result beat is checked before the input beat of the same
    // edge is absorbed, since a result can never belong to a read accepted
    // at the same edge.
    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            width_img = CFG_ACTIVE_BITS_RESET;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                table_img[i] = '0;
            end
        end else begin
            if (m_valid && m_ready) begin
                if (coef_due.size() == 0) begin
                    $error("result beat with no read outstanding: term %0h", m_data.term);
                    err_count++;
                end else begin
                    want = coef_due.pop_front();
                    reads_checked++;
                    if (m_data.term !== want.term) begin
                        $error("term: expected %0h, actual %0h", want.term, m_data.term);
                        err_count++;
                    end
                    if (m_data.coefficients !== want.coefficients) begin
                        $error("coefficients: expected %0h, actual %0h",
                               want.coefficients, m_data.coefficients);
                        err_count++;
                    end
                    if (m_data.any_present !== want.any_present) begin
                        $error("any_present: expected %0h, actual %0h",
                               want.any_present, m_data.any_present);
                        err_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                width_img = cfg_data;
            end
            if (s_valid && s_ready) begin
                beats_in++;
                absorb_beat(s_data);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender. Beats come out of the backlog in bursts of random length with
    // random gaps; a gap of zero gives long stretches at full rate.
    // ------------------------------------------------------------------
    in_beat_t cmd_backlog [$];
    int       burst_left = 0;
    int       gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else if (s_valid && !s_ready) begin
            // The offered beat stays put until it is taken.
        end else if (gap_left > 0) begin
            s_valid <= 1'b0;
            gap_left--;
        end else if (cmd_backlog.size() != 0) begin
            s_data  <= cmd_backlog.pop_front();
            s_valid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver. It switches between stall patterns every so often. Once, after
    // a number of results, it refuses results for a long stretch so that the
    // output register and the sequencer fill and the input side backs up.
    // ------------------------------------------------------------------
    rx_mode_e   rx_mode   = RX_OPEN;
    int         rx_left   = 0;
    int         rx_seen   = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    logic [7:0] rx_tick   = '0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                rx_seen++;
            end
            if (rx_seen == HOLD_AFTER && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = rx_mode_e'($urandom_range(0, 3));
                    rx_left = $urandom_range(16, 160);
                end else begin
                    rx_left--;
                end
                rx_tick++;
                case (rx_mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= rx_tick[2];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus planning. The planner tracks which entries have been written
    // so that no read ever covers an entry the table RAM has never seen; the
    // missing subsets of a term are written first with random values.
    // ------------------------------------------------------------------
    bit written [TABLE_DEPTH];
    int plan_bits     = MAX_BITS;
    int plan_span     = TABLE_DEPTH;
    int counted       = 0;
    int settings_seen = 0;

    function automatic void plan_write(int idx, logic [VALUE_W-1:0] val);
        in_beat_t b;
        b.command     = CMD_WRITE;
        b.index       = idx[TERM_W-1:0];
        b.entry_value = val;
        cmd_backlog.push_back(b);
        // Out-of-range writes are ignored by the block and do not count.
        if (idx < plan_span) begin
            written[idx] = 1'b1;
            counted++;
        end
    endfunction

    function automatic void plan_read(int term);
        in_beat_t          b;
        logic [TERM_W-1:0] t;
        logic [TERM_W-1:0] sub;
        bit                done;
        t = term[TERM_W-1:0];
        if (term < plan_span) begin
            sub  = t;
            done = 1'b0;
            while (!done) begin
                if (!written[sub]) begin
                    plan_write(int'(sub), VALUE_W'($urandom_range(0, 3)));
                end
                if (sub == '0) begin
                    done = 1'b1;
                end else begin
                    sub = (sub - 1'b1) & t;
                end
            end
        end
        b.command     = CMD_READ;
        b.index       = t;
        // The value field is unused on reads; keep it moving anyway.
        b.entry_value = VALUE_W'($urandom_range(0, 3));
        cmd_backlog.push_back(b);
        counted++;
    endfunction

    // Mostly terms with few bits set, so reads stay short; now and then a
    // denser term, and at narrow widths sometimes any term at all.
    function automatic int random_term(int bits);
        int term;
        int k;
        if (bits == 0) begin
            return 0;
        end
        if (bits <= 6 && $urandom_range(0, 19) == 0) begin
            return $urandom_range(0, (1 << bits) - 1);
        end
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, (bits < 7) ? bits : 7)
                                         : $urandom_range(0, 3);
        term = 0;
        repeat (k) term |= 1 << $urandom_range(0, bits - 1);
        return term;
    endfunction

    function automatic void plan_random_beat(int bits);
        int pick;
        int idx;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            plan_read(random_term(bits));
        end else if (pick < 70) begin
            plan_write($urandom_range(0, plan_span - 1), VALUE_W'($urandom_range(0, 3)));
        end else if (pick < 80 && bits < MAX_BITS) begin
            plan_read($urandom_range(plan_span, TABLE_DEPTH - 1));
        end else if (pick < 88 && bits < MAX_BITS) begin
            plan_write($urandom_range(plan_span, TABLE_DEPTH - 1),
                       VALUE_W'($urandom_range(0, 3)));
        end else begin
            // Overwrite an entry and read it straight back as a term.
            idx = random_term(bits);
            plan_write(idx, VALUE_W'($urandom_range(0, 3)));
            plan_read(idx);
        end
    endfunction

    // Widths of the random phases: both extremes, a saturating value, the
    // zero width, and two picked at random.
    function automatic logic [CFG_W-1:0] phase_bits(int ph);
        case (ph)
            0:       return 4'd4;
            1:       return 4'd10;
            2:       return 4'd2;
            3:       return 4'd6;
            4:       return 4'd12;
            5:       return 4'd1;
            6:       return 4'd8;
            7:       return 4'd0;
            8:       return 4'd10;
            default: return CFG_W'($urandom_range(0, 15));
        endcase
    endfunction

    // Wait until every planned beat is accepted and every result checked,
    // then give trailing writes time to land. Sampled on the falling edge so
    // the state of the rising edge has settled.
    task automatic settle();
        @(negedge aclk);
        while (cmd_backlog.size() != 0 || s_valid || coef_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_active_bits(logic [CFG_W-1:0] bits);
        settle();
        @(posedge aclk);
        cfg_data  <= bits;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        plan_bits = (int'(bits) > MAX_BITS) ? MAX_BITS : int'(bits);
        plan_span = 1 << plan_bits;
        settings_seen++;
    endtask

    initial begin
        int quota;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset width: the top entry, both value
        // extremes, a term with only the top bit, and a two-bit term.
        plan_write(0, 2'd3);
        plan_write(TABLE_DEPTH - 1, 2'd2);
        plan_write('h200, 2'd1);
        plan_read(0);
        plan_read('h200);
        plan_write(1, 2'd0);
        plan_write('h201, 2'd3);
        plan_read('h201);

        // Zero width: only index 0 is in range, everything else is ignored
        // on write and reads back as zero.
        set_active_bits(4'd0);
        plan_write(1, 2'd2);
        plan_write(0, 2'd1);
        plan_read(0);
        plan_read(1);
        plan_read(TABLE_DEPTH - 1);

        // Largest register value saturates; the table survives the change.
        set_active_bits(4'd15);
        plan_read('h201);
        plan_read('h200);

        // Narrowest real width, with a write and a read just past the edge.
        set_active_bits(4'd1);
        plan_write(1, 2'd2);
        plan_read(1);
        plan_write(2, 2'd1);
        plan_read(2);
        plan_read(3);

        for (int ph = 0; ph < PHASES; ph++) begin
            set_active_bits(phase_bits(ph));
            quota = counted + (ITEM_GOAL - 25) / PHASES;
            while (counted < quota) begin
                plan_random_beat(plan_bits);
            end
        end

        settle();
        $display("Covered %0d input beats and %0d checked read results over %0d width settings.",
                 beats_in, reads_checked, settings_seen);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #(100_000_000);
        $display("Timeout with %0d results outstanding.", coef_due.size());
        $display("Verification failed");
        $finish;
    end

endmodule
